// File: src/bfk_pkg.sv
// shared constants, types and helper functions of the bunch fir feedback kick
package bfk_pkg;

    localparam int MAX_BUNCHES = 1024;
    localparam int MAX_TAPS    = 6;

    localparam int NUM_COEF    = 6;
    localparam int COEF_IDX_W  = 3;
    localparam int BUNCH_W     = 10;
    localparam int POS_W       = 16;
    localparam int COEF_W      = 18;
    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int TAPS_W      = 3;
    localparam int KICK_W      = 32;

    localparam int ADDR_W      = (MAX_BUNCHES > 1) ? $clog2(MAX_BUNCHES) : 1;
    localparam int SLOT_W      = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int ROW_W       = MAX_TAPS * POS_W;

    localparam int ACC_W       = 38;
    localparam int LO_W        = 19;
    localparam int HI_W        = ACC_W - LO_W;
    localparam int MUL_B_W     = 20;
    localparam int PROD_W      = COEF_W + MUL_B_W;
    localparam int FULL_W      = PROD_W + LO_W + 1;
    localparam int RND_SH      = 17;
    localparam int Q_W         = FULL_W - RND_SH;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_TAPS = CFG_IDX_W'(7);
    localparam logic [TAPS_W-1:0]    TAPS_RST = TAPS_W'(6);

    typedef logic [MAX_TAPS-1:0][POS_W-1:0] t_row;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_GHI,
        ST_GLO,
        ST_ROUND
    } t_state;

    typedef enum logic [1:0] {
        OP_TAP,
        OP_GAIN_HI,
        OP_GAIN_LO
    } t_op_sel;

    typedef struct packed {
        logic    mul_en;
        t_op_sel op;
        logic    acc_clr;
        logic    acc_en;
        logic    hi_lat;
    } t_dp_ctl;

    function automatic logic [CNT_W-1:0] eff_taps(input logic [TAPS_W-1:0] taps);
        logic [CNT_W-1:0] t;
        if (int'(taps) < 2) begin
            t = CNT_W'(2);
        end else if (int'(taps) > MAX_TAPS) begin
            t = CNT_W'(MAX_TAPS);
        end else begin
            t = CNT_W'(taps);
        end
        return t;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_mod(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0]  t);
        logic [CNT_W-1:0] v;
        v = CNT_W'(slot);
        for (int i = 0; i < MAX_TAPS / 2; i++) begin
            if (v >= t) begin
                v = v - t;
            end
        end
        return SLOT_W'(v);
    endfunction

endpackage

// File: src/bunch_fir_feedback_kick.sv
// top level of one plane of the bunch-by-bunch fir feedback kick
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_bunch_index, i_position, i_end_of_turn
//  result   out        o_out_valid / i_out_stall o_kick_bunch, o_kick_value, o_saturated
//  config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// each item runs these steps in order, paced by the single shared multiplier:
// one history read, one multiply per tap, a drain, two gain half-products, rounding
// after reset a clearing pass over all 1024 rows zeroes the history; input stalls then
// a result waits in the output register while the next item is accepted and worked on
// config writes are taken in any cycle
module bunch_fir_feedback_kick (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bfk_pkg::BUNCH_W-1:0]          i_bunch_index,
    input  logic signed [bfk_pkg::POS_W-1:0]     i_position,
    input  logic                                 i_end_of_turn,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bfk_pkg::BUNCH_W-1:0]          o_kick_bunch,
    output logic signed [bfk_pkg::KICK_W-1:0]    o_kick_value,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_we,
    input  logic [bfk_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bfk_pkg::CFG_W-1:0]            i_cfg_data
);
    import bfk_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    t_dp_ctl                  w_ctl;
    logic                     w_mem_we;
    logic                     w_out_load;
    logic                     w_in_acc;
    logic                     w_clr_busy;

    logic signed [COEF_W-1:0] r_coef [NUM_COEF];
    logic signed [COEF_W-1:0] r_gain;
    logic [TAPS_W-1:0]        r_taps;
    logic [SLOT_W-1:0]        r_turn;

    logic [CNT_W-1:0]         w_t;
    logic [SLOT_W-1:0]        w_s;
    logic [CNT_W-1:0]         w_s_inc;

    logic [BUNCH_W-1:0]       r_bunch;
    logic [POS_W-1:0]         r_pos;
    logic [SLOT_W-1:0]        r_s;
    logic [CNT_W-1:0]         r_t;
    logic                     r_inrange;
    logic [SLOT_W-1:0]        r_k;
    logic [SLOT_W-1:0]        r_slot;
    t_row                     r_row;
    t_row                     n_row;

    logic [ROW_W-1:0]         w_rd_data;
    logic signed [KICK_W-1:0] w_kick;
    logic                     w_sat;

    logic                     r_out_valid;
    logic [BUNCH_W-1:0]       r_out_bunch;
    logic signed [KICK_W-1:0] r_out_kick;
    logic                     r_out_sat;

    assign w_in_acc = i_in_valid && (r_state == ST_IDLE);
    assign w_t      = eff_taps(r_taps);
    assign w_s      = slot_mod(r_turn, w_t);
    assign w_s_inc  = CNT_W'(w_s) + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_gain <= '0;
            r_taps <= TAPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN: r_gain <= i_cfg_data;
                REG_TAPS: r_taps <= i_cfg_data[TAPS_W-1:0];
                default:  r_coef[COEF_IDX_W'(i_cfg_idx)] <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_turn  <= '0;
            r_k     <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (i_end_of_turn) begin
                    r_turn <= (w_s_inc == w_t) ? '0 : SLOT_W'(w_s_inc);
                end else begin
                    r_turn <= w_s;
                end
            end
            if (r_state == ST_READ) begin
                r_k    <= '0;
                r_slot <= r_s;
            end else if (r_state == ST_MAC) begin
                r_k    <= r_k + SLOT_W'(1);
                r_slot <= (r_slot == '0) ? SLOT_W'(r_t - CNT_W'(1)) : r_slot - SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_bunch   <= i_bunch_index;
            r_pos     <= i_position;
            r_s       <= w_s;
            r_t       <= w_t;
            r_inrange <= 32'(i_bunch_index) < 32'(MAX_BUNCHES);
        end
        if (r_state == ST_READ) begin
            r_row <= n_row;
        end
    end

    // history row with this turn's sample put in its slot
    always_comb begin
        n_row      = t_row'(w_rd_data);
        n_row[r_s] = r_pos;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (!w_clr_busy) n_state = ST_IDLE;
            ST_IDLE:  if (w_in_acc) n_state = ST_READ;
            ST_READ:  n_state = ST_MAC;
            ST_MAC:   if (CNT_W'(r_k) == r_t - CNT_W'(1)) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_GHI;
            ST_GHI:   n_state = ST_GLO;
            ST_GLO:   n_state = ST_ROUND;
            ST_ROUND: if (!(r_out_valid && i_out_stall)) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        w_ctl      = '{mul_en: 1'b0, op: OP_TAP, acc_clr: 1'b0, acc_en: 1'b0, hi_lat: 1'b0};
        w_mem_we   = 1'b0;
        w_out_load = 1'b0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_READ: begin
                w_ctl.acc_clr = 1'b1;
                w_mem_we      = r_inrange;
            end
            ST_MAC: begin
                w_ctl.mul_en = 1'b1;
                w_ctl.acc_en = (r_k != '0);
            end
            ST_DRAIN: w_ctl.acc_en = 1'b1;
            ST_GHI: begin
                w_ctl.mul_en = 1'b1;
                w_ctl.op     = OP_GAIN_HI;
            end
            ST_GLO: begin
                w_ctl.mul_en = 1'b1;
                w_ctl.op     = OP_GAIN_LO;
                w_ctl.hi_lat = 1'b1;
            end
            ST_ROUND: w_out_load = !(r_out_valid && i_out_stall);
            default: ;
        endcase
    end

    bfk_hist_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_acc),
        .i_rd_addr  (ADDR_W'(i_bunch_index)),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_mem_we),
        .i_wr_addr  (ADDR_W'(r_bunch)),
        .i_wr_data  (ROW_W'(n_row)),
        .o_clr_busy (w_clr_busy)
    );

    bfk_dp u_dp (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_coef (r_coef[COEF_IDX_W'(r_k)]),
        .i_hist (r_row[r_slot]),
        .i_gain (r_gain),
        .o_kick (w_kick),
        .o_sat  (w_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_bunch <= r_bunch;
            r_out_kick  <= r_inrange ? w_kick : '0;
            r_out_sat   <= r_inrange && w_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kick_bunch = r_out_bunch;
    assign o_kick_value = r_out_kick;
    assign o_saturated  = r_out_sat;

endmodule

// File: src/bfk_hist_mem.sv
// per-bunch position history memory, one row of all turn slots per bunch
module bfk_hist_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [bfk_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [bfk_pkg::ROW_W-1:0]  o_rd_data,
    input  logic                       i_wr_en,
    input  logic [bfk_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [bfk_pkg::ROW_W-1:0]  i_wr_data,
    output logic                       o_clr_busy
);
    import bfk_pkg::*;

    logic [ROW_W-1:0]  mem [MAX_BUNCHES];
    logic [ROW_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_busy;

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(MAX_BUNCHES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

// File: src/bfk_dp.sv
// shared multiplier, tap accumulator and gain rounding with saturation
module bfk_dp (
    input  logic                              i_clk,
    input  bfk_pkg::t_dp_ctl                  i_ctl,
    input  logic signed [bfk_pkg::COEF_W-1:0] i_coef,
    input  logic signed [bfk_pkg::POS_W-1:0]  i_hist,
    input  logic signed [bfk_pkg::COEF_W-1:0] i_gain,
    output logic signed [bfk_pkg::KICK_W-1:0] o_kick,
    output logic                              o_sat
);
    import bfk_pkg::*;

    logic signed [COEF_W-1:0]  w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_ph;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [FULL_W-1:0]  w_full;
    logic signed [Q_W-1:0]     w_q;
    logic                      w_ovf;

    always_comb begin
        case (i_ctl.op)
            OP_GAIN_HI: begin
                w_a = i_gain;
                w_b = {{(MUL_B_W - HI_W){r_acc[ACC_W-1]}}, r_acc[ACC_W-1:LO_W]};
            end
            OP_GAIN_LO: begin
                w_a = i_gain;
                w_b = {{(MUL_B_W - LO_W){1'b0}}, r_acc[LO_W-1:0]};
            end
            default: begin
                w_a = i_coef;
                w_b = {{(MUL_B_W - POS_W){i_hist[POS_W-1]}}, i_hist};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_a * w_b;
        end
        if (i_ctl.hi_lat) begin
            r_ph <= r_prod;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    // gain * sum rebuilt from the two halves, round half up, floor shift
    always_comb begin
        w_full = {r_ph[PROD_W-1], r_ph, {LO_W{1'b0}}}
               + {{(FULL_W - PROD_W){r_prod[PROD_W-1]}}, r_prod}
               + FULL_W'(1 << (RND_SH - 1));
        w_q    = w_full[FULL_W-1:RND_SH];
        w_ovf  = (w_q[Q_W-1:KICK_W-1] != '0) && (w_q[Q_W-1:KICK_W-1] != '1);
        o_sat  = w_ovf;
        if (w_ovf) begin
            o_kick = w_q[Q_W-1] ? {1'b1, {(KICK_W-1){1'b0}}} : {1'b0, {(KICK_W-1){1'b1}}};
        end else begin
            o_kick = w_q[KICK_W-1:0];
        end
    end

endmodule

// File: verif/bunch_fir_feedback_kick_test.sv
// self-checking testbench of the bunch fir feedback kick with its own filter predictor
module bunch_fir_feedback_kick_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfk_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          IDLE_PCT      = 23;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = CFG_IDX_W'(0);
    localparam longint      KICK_MAX      = 64'sd2147483647;
    localparam longint      KICK_MIN      = -64'sd2147483648;
    localparam longint      Q18_MAX       = 131071;
    localparam longint      Q18_MIN       = -131072;

    typedef struct {
        logic [BUNCH_W-1:0]        bunch;
        logic signed [KICK_W-1:0]  value;
        logic                      sat;
    } t_kick_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [BUNCH_W-1:0]          i_bunch_index = '0;
    logic signed [POS_W-1:0]     i_position = '0;
    logic                        i_end_of_turn = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [BUNCH_W-1:0]          o_kick_bunch;
    logic signed [KICK_W-1:0]    o_kick_value;
    logic                        o_saturated;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    logic signed [COEF_W-1:0]    filt_coef [NUM_COEF];
    logic signed [COEF_W-1:0]    filt_gain = '0;
    logic [TAPS_W-1:0]           filt_taps = TAPS_RST;
    int                          filt_slot = 0;
    logic signed [POS_W-1:0]     bunch_history [MAX_TAPS][MAX_BUNCHES];
    t_kick_result                expected_kicks [$];

    int                          in_idle_pct = IDLE_PCT;
    int                          out_idle_pct = IDLE_PCT;
    int                          hold_req = 0;
    int                          hold_ack = 0;
    int                          hold_left = 0;
    int                          mismatch_count = 0;
    int unsigned                 cycle_count = 0;

    bunch_fir_feedback_kick dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_kick_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_kicks.size() == 0) begin
                $error("kick for bunch %0d with no item waiting", o_kick_bunch);
                mismatch_count++;
            end else begin
                want = expected_kicks.pop_front();
                if (o_kick_bunch !== want.bunch) begin
                    $error("kick_bunch: expected %0d, actual %0d", want.bunch, o_kick_bunch);
                    mismatch_count++;
                end
                if (o_kick_value !== want.value) begin
                    $error("kick_value: expected %0d, actual %0d", want.value, o_kick_value);
                    mismatch_count++;
                end
                if (o_saturated !== want.sat) begin
                    $error("saturated: expected %0d, actual %0d", want.sat, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void predict_kick(input logic [BUNCH_W-1:0] bunch,
                                         input logic signed [POS_W-1:0] pos,
                                         input logic eot);
        int           taps;
        int           slot;
        longint       sum;
        longint       scaled;
        t_kick_result res;
        taps = (filt_taps < 2) ? 2 : (filt_taps > MAX_TAPS) ? MAX_TAPS : int'(filt_taps);
        slot = filt_slot % taps;
        scaled = 0;
        res.sat = 1'b0;
        if (int'(bunch) < MAX_BUNCHES) begin
            bunch_history[slot][bunch] = pos;
            sum = 0;
            for (int age = 0; age < taps; age++) begin
                sum += longint'(filt_coef[age])
                       * longint'(bunch_history[(slot + taps - age) % taps][bunch]);
            end
            // round half up to the kick lsb
            scaled = (longint'(filt_gain) * sum + 65536) >>> 17;
            if (scaled > KICK_MAX) begin
                scaled  = KICK_MAX;
                res.sat = 1'b1;
            end else if (scaled < KICK_MIN) begin
                scaled  = KICK_MIN;
                res.sat = 1'b1;
            end
        end
        res.bunch = bunch;
        res.value = scaled[KICK_W-1:0];
        expected_kicks.push_back(res);
        filt_slot = eot ? (slot + 1) % taps : slot;
    endfunction

    function automatic longint rand_signed(input int width);
        int     nbits;
        longint v;
        nbits = $urandom_range(width, 1);
        v = {$urandom, $urandom};
        v = (v <<< (64 - nbits)) >>> (64 - nbits);
        case ($urandom_range(9))
            0: v = -(64'sd1 <<< (width - 1));
            1: v = (64'sd1 <<< (width - 1)) - 1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic offer_sample(input logic [BUNCH_W-1:0] bunch,
                                input logic signed [POS_W-1:0] pos,
                                input logic eot);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (in_idle_pct != 0 && $urandom_range(99) < 3) gap += $urandom_range(15, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_bunch_index <= bunch;
        i_position    <= pos;
        i_end_of_turn <= eot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_kick(bunch, pos, eot);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_kicks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_COEF) begin
            filt_coef[idx] = value[COEF_W-1:0];
        end else if (idx == REG_GAIN) begin
            filt_gain = value[COEF_W-1:0];
        end else if (idx == REG_TAPS) begin
            filt_taps = value[TAPS_W-1:0];
        end
    endtask

    task automatic load_filter(input longint c0, input longint c1, input longint c2,
                               input longint c3, input longint c4, input longint c5,
                               input longint gain, input longint taps);
        write_reg(REG_COEF0, c0);
        write_reg(REG_COEF0 + CFG_IDX_W'(1), c1);
        write_reg(REG_COEF0 + CFG_IDX_W'(2), c2);
        write_reg(REG_COEF0 + CFG_IDX_W'(3), c3);
        write_reg(REG_COEF0 + CFG_IDX_W'(4), c4);
        write_reg(REG_COEF0 + CFG_IDX_W'(5), c5);
        write_reg(REG_GAIN, gain);
        write_reg(REG_TAPS, taps);
    endtask

    // mostly whole turns over a small bunch train, some stray items
    task automatic run_random_turns(input int n);
        int sent;
        int width;
        int base;
        int turns;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 85) begin
                width = $urandom_range(6, 1);
                base  = $urandom_range(MAX_BUNCHES - width, 0);
                turns = $urandom_range(8, 2);
                repeat (turns) begin
                    for (int b = 0; b < width; b++) begin
                        offer_sample(BUNCH_W'(base + b), POS_W'(rand_signed(POS_W)),
                                     b == width - 1 && $urandom_range(19) != 0);
                        sent++;
                    end
                end
            end else begin
                offer_sample(BUNCH_W'($urandom), POS_W'(rand_signed(POS_W)), 1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        offer_sample(BUNCH_W'(0), 16'sh7FFF, 1'b0);
        offer_sample(BUNCH_W'(MAX_BUNCHES - 1), 16'sh8000, 1'b1);
        drain_results();
    endtask

    task automatic test_saturation_and_rounding();
        load_filter(Q18_MAX, 0, 0, 0, 0, 0, Q18_MAX, 6);
        offer_sample(BUNCH_W'(5), 16'sh7FFF, 1'b0);
        offer_sample(BUNCH_W'(6), 16'sh8000, 1'b0);
        drain_results();
        load_filter(Q18_MAX, 0, 0, 0, 0, 0, Q18_MIN, 6);
        offer_sample(BUNCH_W'(10), 16'sh7FFF, 1'b0);
        drain_results();
        // exact halves of both signs and a whole negative value
        load_filter(1, 0, 0, 0, 0, 0, 65536, 6);
        offer_sample(BUNCH_W'(7), 16'sd1, 1'b0);
        offer_sample(BUNCH_W'(8), -16'sd1, 1'b0);
        offer_sample(BUNCH_W'(9), -16'sd2, 1'b0);
        drain_results();
    endtask

    task automatic test_taps_range();
        load_filter(20000, -30000, 25000, -15000, 10000, 5000, 300, 0);
        offer_sample(BUNCH_W'(3), 16'sd1000, 1'b1);
        offer_sample(BUNCH_W'(3), -16'sd2000, 1'b1);
        offer_sample(BUNCH_W'(3), 16'sd3000, 1'b1);
        drain_results();
        write_reg(REG_TAPS, 1);
        offer_sample(BUNCH_W'(3), 16'sd500, 1'b1);
        offer_sample(BUNCH_W'(4), 16'sh7FFF, 1'b1);
        drain_results();
        write_reg(REG_TAPS, 7);
        repeat (3) offer_sample(BUNCH_W'(3), -16'sd700, 1'b1);
        drain_results();
    endtask

    task automatic test_slot_beyond_taps();
        write_reg(REG_TAPS, 6);
        while (filt_slot != 5) offer_sample(BUNCH_W'(12), POS_W'(rand_signed(POS_W)), 1'b1);
        drain_results();
        write_reg(REG_TAPS, 2);
        offer_sample(BUNCH_W'(12), 16'sd4000, 1'b1);
        offer_sample(BUNCH_W'(12), -16'sd4000, 1'b0);
        drain_results();
    endtask

    task automatic test_random_settings();
        longint upper;
        for (int ph = 0; ph < 8; ph++) begin
            upper = longint'($urandom_range(32767)) <<< TAPS_W;
            case (ph)
                0: load_filter(Q18_MAX, Q18_MAX, Q18_MAX, Q18_MAX, Q18_MAX, Q18_MAX,
                               Q18_MAX, upper | ph);
                1: load_filter(Q18_MIN, Q18_MIN, Q18_MIN, Q18_MIN, Q18_MIN, Q18_MIN,
                               Q18_MIN, upper | ph);
                default: load_filter(rand_signed(COEF_W), rand_signed(COEF_W),
                                     rand_signed(COEF_W), rand_signed(COEF_W),
                                     rand_signed(COEF_W), rand_signed(COEF_W),
                                     rand_signed(COEF_W), upper | ph);
            endcase
            run_random_turns(170);
            drain_results();
        end
    endtask

    task automatic test_back_to_back();
        load_filter(rand_signed(COEF_W), rand_signed(COEF_W), rand_signed(COEF_W),
                    rand_signed(COEF_W), rand_signed(COEF_W), rand_signed(COEF_W),
                    rand_signed(COEF_W), 6);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random_turns(200);
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
        drain_results();
    endtask

    task automatic test_output_hold();
        write_reg(REG_TAPS, 4);
        hold_req++;
        in_idle_pct = 0;
        run_random_turns(60);
        in_idle_pct = IDLE_PCT;
        drain_results();
    endtask

    task automatic test_sender_pause();
        run_random_turns(30);
        drain_results();
        run_random_turns(30);
        drain_results();
    endtask

    initial begin
        for (int k = 0; k < NUM_COEF; k++) filt_coef[k] = '0;
        for (int s = 0; s < MAX_TAPS; s++) begin
            for (int b = 0; b < MAX_BUNCHES; b++) bunch_history[s][b] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_saturation_and_rounding();
        test_taps_range();
        test_slot_beyond_taps();
        test_random_settings();
        test_back_to_back();
        test_output_hold();
        test_sender_pause();
        drain_results();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/bfk_pkg.sv
src/bfk_hist_mem.sv
src/bfk_dp.sv
src/bunch_fir_feedback_kick.sv
verif/bunch_fir_feedback_kick_test.sv
